[rtl/tba_pkg.sv]
// ----------------------------------------------------------------------------
// tba_pkg
// Shared constants, codes and types of the tagged block allocator.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_WORDS = 2;

    localparam int OP_W    = 2;
    localparam int TAG_W   = 16;
    localparam int LEN_W   = 24;
    localparam int ADDR_W  = 24;
    localparam int ST_W    = 3;
    localparam int BCNT_W  = 7;
    localparam int LIMIT_W = 25;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(25'h100_0000);

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_LIST = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_TAG  = 3'd2;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_MEM  = 3'd4;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

[rtl/tba_if.sv]
// ----------------------------------------------------------------------------
// tba_if
// Valid/ready channels of the allocator: request, response and config write.
// ----------------------------------------------------------------------------
interface tba_req_if;
    logic                       valid;
    logic                       ready;
    logic [tba_pkg::OP_W-1:0]   opcode;
    logic [tba_pkg::TAG_W-1:0]  block_tag;
    logic [tba_pkg::LEN_W-1:0]  request_length;

    modport source (output valid, output opcode, output block_tag,
                    output request_length, input ready);
    modport sink   (input valid, input opcode, input block_tag,
                    input request_length, output ready);
endinterface

interface tba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [tba_pkg::ST_W-1:0]   status;
    logic [tba_pkg::ADDR_W-1:0] start_addr;
    logic [tba_pkg::LEN_W-1:0]  block_length;
    logic [tba_pkg::BCNT_W-1:0] block_count;

    modport source (output valid, output status, output start_addr,
                    output block_length, output block_count, input ready);
    modport sink   (input valid, input status, input start_addr,
                    input block_length, input block_count, output ready);
endinterface

interface tba_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tba_pkg::LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/tagged_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// tagged_block_allocator_top
// Append-only allocator of tagged blocks; block list held in an on-chip table.
// ----------------------------------------------------------------------------
// One request is handled at a time. Clear, and lookup on an absent list, go
// from accept straight to the finish state; allocate and lookup first scan the
// list, which holds at most 64 blocks, through the single read port of the
// block table, one entry per cycle. A finished result waits in the output
// register while the next request is taken. The table needs no clearing pass;
// the memory_limit write port is always ready.
module tagged_block_allocator_top (
    input  logic       clk,
    input  logic       rst_n,
    tba_req_if.sink    req,
    tba_rsp_if.source  rsp,
    tba_cfg_if.sink    cfg
);
    import tba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               list_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LIMIT_W-1:0] free_reg;

    logic [OP_W-1:0]    op_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               nolist_reg;
    logic               hit_reg;
    logic [ADDR_W-1:0]  found_start_reg;
    logic [LEN_W-1:0]   found_len_reg;

    logic [CNT_W-1:0]   issue_reg;
    logic               cmp_vld_reg;

    logic               rsp_valid_reg;
    logic [ST_W-1:0]    st_reg;
    logic [ADDR_W-1:0]  start_reg;
    logic [LEN_W-1:0]   blen_reg;
    logic [BCNT_W-1:0]  bcnt_reg;

    entry_t             mem [MAX_BLOCKS];
    entry_t             rd_data_reg;
    entry_t             wr_data;
    logic               mem_re;
    logic               mem_we;

    logic               req_fire;
    logic               out_free;
    logic               cmp_hit;
    logic               scan_done;
    logic [LIMIT_W:0]   end_sum;
    logic               no_mem;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = st_reg;
    assign rsp.start_addr   = start_reg;
    assign rsp.block_length = blen_reg;
    assign rsp.block_count  = bcnt_reg;

    assign cmp_hit   = cmp_vld_reg && (rd_data_reg.tag == tag_reg);
    assign scan_done = cmp_hit || ((issue_reg == count_reg) && !cmp_vld_reg)
                       || ((issue_reg == count_reg) && cmp_vld_reg);
    assign mem_re    = (state_reg == S_SCAN) && (issue_reg < count_reg) && !cmp_hit;

    assign end_sum = (LIMIT_W + 1)'(free_reg) + (LIMIT_W + 1)'(len_reg)
                     + (LIMIT_W + 1)'(HEADER_WORDS);
    assign no_mem  = (end_sum >= (LIMIT_W + 1)'(limit_reg))
                     || (count_reg >= CNT_W'(MAX_BLOCKS));

    assign wr_data.tag   = tag_reg;
    assign wr_data.start = ADDR_W'(free_reg + LIMIT_W'(HEADER_WORDS));
    assign wr_data.len   = len_reg;
    assign mem_we = (state_reg == S_FIN) && out_free && (op_reg == OP_ALLOC)
                    && !hit_reg && !no_mem;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.opcode == OP_CLEAR || (!list_reg && req.opcode != OP_ALLOC))
                        state_next = S_FIN;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        if (mem_re)
            rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg     <= req.opcode;
            tag_reg    <= req.block_tag;
            len_reg    <= req.request_length;
            nolist_reg <= !list_reg && req.opcode != OP_ALLOC;
        end
        if (cmp_hit && state_reg == S_SCAN)
        begin
            found_start_reg <= rd_data_reg.start;
            found_len_reg   <= rd_data_reg.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_CAP;
            list_reg      <= 1'b0;
            count_reg     <= '0;
            free_reg      <= LIMIT_W'(HEADER_WORDS);
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            st_reg        <= ST_OK;
            start_reg     <= '0;
            blen_reg      <= '0;
            bcnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
                limit_reg <= (cfg.data > LIMIT_CAP) ? LIMIT_CAP : cfg.data;

            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;

            if (req_fire)
            begin
                issue_reg   <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
                if (req.opcode == OP_ALLOC)
                    list_reg <= 1'b1;
            end

            if (state_reg == S_SCAN)
            begin
                cmp_vld_reg <= mem_re;
                if (mem_re)
                    issue_reg <= issue_reg + CNT_W'(1);
                if (cmp_hit)
                    hit_reg <= 1'b1;
            end

            if (state_reg == S_FIN && out_free)
            begin
                rsp_valid_reg <= 1'b1;
                start_reg     <= '0;
                blen_reg      <= '0;
                bcnt_reg      <= BCNT_W'(count_reg);
                if (op_reg == OP_CLEAR)
                begin
                    list_reg <= 1'b0;
                    count_reg <= '0;
                    free_reg <= LIMIT_W'(HEADER_WORDS);
                    st_reg   <= ST_OK;
                    bcnt_reg <= '0;
                end
                else if (nolist_reg)
                begin
                    st_reg   <= ST_NO_LIST;
                    bcnt_reg <= '0;
                end
                else if (hit_reg)
                begin
                    st_reg    <= (op_reg == OP_ALLOC) ? ST_PRESENT : ST_OK;
                    start_reg <= found_start_reg;
                    blen_reg  <= found_len_reg;
                end
                else if (op_reg != OP_ALLOC)
                    st_reg <= ST_NO_TAG;
                else if (no_mem)
                    st_reg <= ST_NO_MEM;
                else
                begin
                    st_reg    <= ST_OK;
                    start_reg <= wr_data.start;
                    blen_reg  <= len_reg;
                    count_reg <= count_reg + CNT_W'(1);
                    bcnt_reg  <= BCNT_W'(count_reg + CNT_W'(1));
                    free_reg  <= end_sum[LIMIT_W-1:0];
                end
            end
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_nolist_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !list_reg |-> (count_reg == '0 && free_reg == LIMIT_W'(HEADER_WORDS)))
        else $error("absent list holds blocks");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not advance count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> issue_reg <= count_reg)
        else $error("scan ran past list end");

endmodule
